### design/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared widths, codes and controller/datapath interface types for the
// trapezoidal velocity profile core.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int REG_W  = 31;
  localparam int OUT_W  = 32;
  localparam int IDX_W  = 3;
  localparam int PH_W   = 2;
  localparam int WIDE_W = 64;
  localparam int HALF_W = 32;
  localparam int CNT_W  = $clog2(WIDE_W);

  localparam logic [REG_W-1:0] ACCEL_RST = 31'd65536;
  localparam logic [REG_W-1:0] VMAX_RST  = 31'd65536;

  localparam logic [IDX_W-1:0] REG_PATH_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_ACCEL_RATE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_VEL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_VEL     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_VEL     = 3'd4;

  localparam logic [PH_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PH_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PH_W-1:0] PH_DECEL  = 2'd2;
  localparam logic [PH_W-1:0] PH_DONE   = 2'd3;

  localparam logic [WIDE_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;
  localparam logic [WIDE_W-1:0] TIME_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_SETUP,
    CMD_SQ_VM,
    CMD_SQ_V0,
    CMD_SQ_V1,
    CMD_AL,
    CMD_XD_GO,
    CMD_XD_ST,
    CMD_X1_GO,
    CMD_X1_ST,
    CMD_T1_GO,
    CMD_T1_ST,
    CMD_TC_GO,
    CMD_TC_ST,
    CMD_RT_GO,
    CMD_RT_ST,
    CMD_PK_SQ,
    CMD_TD_GO,
    CMD_TD_ST,
    CMD_FIN,
    CMD_LOC,
    CMD_DV,
    CMD_MID,
    CMD_LO,
    CMD_HI,
    CMD_RES
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic plan_valid;
    logic trap;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

### design/trapezoid_velocity_profile_core.sv
// with a cached plan a sample steps through LOC, DV, MID, LO, HI and RES; RES waits
// while the output word is stalled. The first sample after reset or a register write
// also plans the move: five divides (trapezoid) or three divides and a root (triangle)
// a new sample is taken only when idle; all products share the single 32x32 multiplier
// reset: move registers take their reset values, plan is invalid, no word pending
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile_core
// Trapezoidal / triangular velocity profile generator: plans a move from its
// registers and returns position, speed and phase for each sample time.
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile_core import tvp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [REG_W-1:0]        in_sample_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_position,
  output logic signed [OUT_W-1:0] out_speed,
  output logic [PH_W-1:0]         out_phase,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  ctrl_t ctrl;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  tvp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  tvp_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_time (in_sample_time),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_position   (out_position),
    .out_speed      (out_speed),
    .out_phase      (out_phase)
  );

  a_cfg_drops_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index <= REG_MAX_VEL)) |=> !stat.plan_valid)
    else $error("plan still valid after register write");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (ctrl.cmd == CMD_XD_ST || ctrl.cmd == CMD_X1_ST ||
                       ctrl.cmd == CMD_T1_ST || ctrl.cmd == CMD_TC_ST ||
                       ctrl.cmd == CMD_TD_ST))
    else $error("divider finished outside a wait step");

  a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.cmd == CMD_RES) |-> stat.out_free)
    else $error("result loaded over a stalled word");

  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |-> (ctrl.cmd == CMD_NONE && !in_stall))
    else $error("sample taken while busy");

endmodule

### design/tvp_div.sv
// ----------------------------------------------------------------------------
// tvp_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module tvp_div import tvp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] dividend,
  input  logic [HALF_W-1:0] divisor,
  output logic              done,
  output logic [WIDE_W-1:0] quotient
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDE_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [HALF_W-1:0] rem_r, rem_nxt;
  logic [HALF_W-1:0] dsr_r, dsr_nxt;
  logic [WIDE_W-1:0] quo_r, quo_nxt;
  logic [HALF_W:0]   rem_sh;
  logic [HALF_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[WIDE_W-1]};
    rem_sub  = rem_sh - {1'b0, dsr_r};
    ge       = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[HALF_W-1:0] : rem_sh[HALF_W-1:0];
      quo_nxt = {quo_r[WIDE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### design/tvp_sqrt.sv
// ----------------------------------------------------------------------------
// tvp_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tvp_sqrt import tvp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] radicand,
  output logic              done,
  output logic [HALF_W-1:0] root
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WIDE_W-1:0] n_r, n_nxt;
  logic [WIDE_W-1:0] r_r, r_nxt;
  logic [WIDE_W-1:0] probe_r, probe_nxt;
  logic [WIDE_W-1:0] sum;
  logic              ge;

  always_comb begin
    sum       = r_r + probe_r;
    ge        = (n_r >= sum);
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    n_nxt     = n_r;
    r_nxt     = r_r;
    probe_nxt = probe_r;
    if (start) begin
      busy_nxt  = 1'b1;
      n_nxt     = radicand;
      r_nxt     = '0;
      probe_nxt = SQRT_TOP;
    end else if (busy_r) begin
      if (ge) begin
        n_nxt = n_r - sum;
        r_nxt = (r_r >> 1) + probe_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      probe_nxt = probe_r >> 2;
      if (probe_r == WIDE_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    r_r     <= r_nxt;
    probe_r <= probe_nxt;
  end

  assign done = done_r;
  assign root = r_r[HALF_W-1:0];

endmodule

### design/tvp_datapath.sv
// ----------------------------------------------------------------------------
// tvp_datapath
// Move registers, cached plan, shared multiplier, divider and root units,
// sample evaluation and the output word register.
// ----------------------------------------------------------------------------
module tvp_datapath import tvp_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic [REG_W-1:0]        in_sample_time,
  input  ctrl_t                   ctrl,
  output stat_t                   stat,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_position,
  output logic signed [OUT_W-1:0] out_speed,
  output logic [PH_W-1:0]         out_phase
);

  localparam logic signed [WIDE_W-1:0] VAL_HI =
    (WIDE_W'(1) << (VALUE_WIDTH - 1)) - WIDE_W'(1);
  localparam logic signed [WIDE_W-1:0] VAL_LO = ~VAL_HI;

  function automatic logic signed [WIDE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] res;
    res = v;
    if (v > VAL_HI) res = VAL_HI;
    else if (v < VAL_LO) res = VAL_LO;
    return res;
  endfunction

  function automatic logic [WIDE_W-1:0] sat_time(input logic [WIDE_W-1:0] t);
    return (t > TIME_MAX) ? TIME_MAX : t;
  endfunction

  // move registers
  logic [REG_W-1:0] len_r, acc_r, v0c_r, v1c_r, vmc_r;
  logic             plan_valid_r;

  // plan
  logic [REG_W-1:0]  a_r, vm_r, v0_r, v1_r;
  logic [HALF_W-1:0] peak_r;
  logic [WIDE_W-1:0] sqa_r, sq0_r, sq1_r, al_r, sqp_r, xd_r;
  logic [WIDE_W-1:0] x1_r, x2_r, t1_r, t2_r, t3_r;

  // sample
  logic [REG_W-1:0]  t_r, d_r;
  logic [PH_W-1:0]   ph_r;
  logic [WIDE_W-1:0] dv_r, m_r, spd_r, lo_r, pm_r;

  // output word
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pos_out_r, spd_out_r;
  logic [PH_W-1:0]         ph_out_r;

  logic [REG_W-1:0]  a_fix, vm_fix, v0_fix, v1_fix;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [WIDE_W-1:0] div_dvd, div_q;
  logic [HALF_W-1:0] div_dsr;
  logic              sqrt_start, sqrt_done;
  logic [WIDE_W-1:0] sqrt_arg;
  logic [HALF_W-1:0] sqrt_root;
  logic [HALF_W-1:0] peak_fix;
  logic [WIDE_W+1:0] cmp_lhs, cmp_rhs;
  logic              trap;
  logic [WIDE_W-1:0] t64, peak64, v0_64, v1_64, a64;
  logic [PH_W-1:0]   loc_ph;
  logic [WIDE_W-1:0] loc_d;
  logic [WIDE_W-1:0] m_nxt, spd_nxt;
  logic signed [WIDE_W-1:0] pos_w, pos_sat, spd_sat;
  logic              out_free;

  assign a_fix  = (acc_r == '0) ? REG_W'(1) : acc_r;
  assign vm_fix = (vmc_r == '0) ? REG_W'(1) : vmc_r;
  assign v0_fix = (v0c_r > vm_fix) ? vm_fix : v0c_r;
  assign v1_fix = (v1c_r > vm_fix) ? vm_fix : v1c_r;

  assign t64    = {{(WIDE_W-REG_W){1'b0}}, t_r};
  assign peak64 = {{(WIDE_W-HALF_W){1'b0}}, peak_r};
  assign v0_64  = {{(WIDE_W-REG_W){1'b0}}, v0_r};
  assign v1_64  = {{(WIDE_W-REG_W){1'b0}}, v1_r};
  assign a64    = {{(WIDE_W-REG_W){1'b0}}, a_r};

  assign cmp_lhs = {1'b0, sqa_r, 1'b0};
  assign cmp_rhs = {1'b0, al_r, 1'b0} + {2'b00, sq0_r} + {2'b00, sq1_r};
  assign trap    = (cmp_lhs < cmp_rhs);

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.cmd)
      CMD_SQ_VM: begin
        mul_a = {1'b0, vm_r};
        mul_b = {1'b0, vm_r};
      end
      CMD_SQ_V0: begin
        mul_a = {1'b0, v0_r};
        mul_b = {1'b0, v0_r};
      end
      CMD_SQ_V1: begin
        mul_a = {1'b0, v1_r};
        mul_b = {1'b0, v1_r};
      end
      CMD_AL: begin
        mul_a = {1'b0, a_r};
        mul_b = {1'b0, len_r};
      end
      CMD_PK_SQ: begin
        mul_a = peak_r;
        mul_b = peak_r;
      end
      CMD_DV: begin
        mul_a = {1'b0, a_r};
        mul_b = {1'b0, d_r};
      end
      CMD_LO: begin
        mul_a = m_r[HALF_W-1:0];
        mul_b = {1'b0, d_r};
      end
      CMD_HI: begin
        mul_a = m_r[WIDE_W-1:HALF_W];
        mul_b = {1'b0, d_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    case (ctrl.cmd)
      CMD_XD_GO: begin
        div_start = 1'b1;
        div_dvd   = sqa_r - sq1_r;
        div_dsr   = {a_r, 1'b0};
      end
      CMD_X1_GO: begin
        div_start = 1'b1;
        div_dvd   = sqp_r - sq0_r;
        div_dsr   = {a_r, 1'b0};
      end
      CMD_T1_GO: begin
        div_start = 1'b1;
        div_dvd   = (peak64 - v0_64) << FRAC_BITS;
        div_dsr   = {1'b0, a_r};
      end
      CMD_TC_GO: begin
        div_start = 1'b1;
        div_dvd   = (x2_r - x1_r) << FRAC_BITS;
        div_dsr   = {1'b0, vm_r};
      end
      CMD_TD_GO: begin
        div_start = 1'b1;
        div_dvd   = (peak64 - v1_64) << FRAC_BITS;
        div_dsr   = {1'b0, a_r};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (ctrl.cmd == CMD_RT_GO);
  assign sqrt_arg   = al_r + ((sq0_r + sq1_r) >> 1);

  tvp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  tvp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_arg),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // triangular peak never below either end speed
  always_comb begin
    peak_fix = sqrt_root;
    if (peak_fix < {1'b0, v0_r}) peak_fix = {1'b0, v0_r};
    if (peak_fix < {1'b0, v1_r}) peak_fix = {1'b0, v1_r};
  end

  // phase location
  always_comb begin
    if (t64 < t1_r) begin
      loc_ph = PH_ACCEL;
      loc_d  = t64;
    end else if (t64 < t2_r) begin
      loc_ph = PH_CRUISE;
      loc_d  = t64 - t1_r;
    end else if (t64 < t3_r) begin
      loc_ph = PH_DECEL;
      loc_d  = t64 - t2_r;
    end else begin
      loc_ph = PH_DONE;
      loc_d  = '0;
    end
  end

  always_comb begin
    case (ph_r)
      PH_ACCEL: begin
        m_nxt   = (v0_64 << 1) + dv_r;
        spd_nxt = v0_64 + dv_r;
      end
      PH_CRUISE: begin
        m_nxt   = peak64;
        spd_nxt = peak64;
      end
      PH_DECEL: begin
        m_nxt   = (peak64 << 1) - dv_r;
        spd_nxt = peak64 - dv_r;
      end
      default: begin
        m_nxt   = '0;
        spd_nxt = v1_64;
      end
    endcase
  end

  always_comb begin
    case (ph_r)
      PH_ACCEL:  pos_w = signed'(pm_r >> (FRAC_BITS + 1));
      PH_CRUISE: pos_w = signed'(x1_r) + signed'(pm_r >> FRAC_BITS);
      PH_DECEL:  pos_w = signed'(x2_r) + signed'(pm_r >> (FRAC_BITS + 1));
      default:   pos_w = signed'({{(WIDE_W-REG_W){1'b0}}, len_r});
    endcase
  end

  assign pos_sat  = sat_val(pos_w);
  assign spd_sat  = sat_val(signed'(spd_r));
  assign out_free = !out_valid_r || !out_stall;

  // move registers and plan flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      acc_r        <= ACCEL_RST;
      v0c_r        <= '0;
      v1c_r        <= '0;
      vmc_r        <= VMAX_RST;
      plan_valid_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATH_LENGTH: begin
          len_r        <= cfg_data;
          plan_valid_r <= 1'b0;
        end
        REG_ACCEL_RATE: begin
          acc_r        <= cfg_data;
          plan_valid_r <= 1'b0;
        end
        REG_START_VEL: begin
          v0c_r        <= cfg_data;
          plan_valid_r <= 1'b0;
        end
        REG_END_VEL: begin
          v1c_r        <= cfg_data;
          plan_valid_r <= 1'b0;
        end
        REG_MAX_VEL: begin
          vmc_r        <= cfg_data;
          plan_valid_r <= 1'b0;
        end
        default: begin
          plan_valid_r <= plan_valid_r;
        end
      endcase
    end else if (ctrl.cmd == CMD_FIN) begin
      plan_valid_r <= 1'b1;
    end
  end

  // plan, sample working and output word registers
  always_ff @(posedge clk) begin
    if (ctrl.take) t_r <= in_sample_time;
    case (ctrl.cmd)
      CMD_SETUP: begin
        a_r  <= a_fix;
        vm_r <= vm_fix;
        v0_r <= v0_fix;
        v1_r <= v1_fix;
      end
      CMD_SQ_VM: sqa_r <= mul_p;
      CMD_SQ_V0: sq0_r <= mul_p;
      CMD_SQ_V1: sq1_r <= mul_p;
      CMD_AL:    al_r  <= mul_p;
      CMD_XD_GO: begin
        peak_r <= {1'b0, vm_r};
        sqp_r  <= sqa_r;
      end
      CMD_XD_ST: if (div_done) xd_r <= div_q;
      CMD_X1_ST: begin
        if (div_done) begin
          x1_r <= div_q;
          x2_r <= trap ? ({{(WIDE_W-REG_W){1'b0}}, len_r} - xd_r) : div_q;
        end
      end
      CMD_T1_ST: begin
        if (div_done) begin
          t1_r <= div_q;
          t2_r <= div_q;
        end
      end
      CMD_TC_ST: if (div_done) t2_r <= t1_r + div_q;
      CMD_RT_ST: if (sqrt_done) peak_r <= peak_fix;
      CMD_PK_SQ: sqp_r <= mul_p;
      CMD_TD_ST: if (div_done) t3_r <= t2_r + div_q;
      CMD_FIN: begin
        t1_r <= sat_time(t1_r);
        t2_r <= sat_time(t2_r);
        t3_r <= sat_time(t3_r);
        x1_r <= sat_val(signed'(x1_r));
        x2_r <= sat_val(signed'(x2_r));
      end
      CMD_LOC: begin
        ph_r <= loc_ph;
        d_r  <= loc_d[REG_W-1:0];
      end
      CMD_DV: dv_r <= mul_p >> FRAC_BITS;
      CMD_MID: begin
        m_r   <= m_nxt;
        spd_r <= spd_nxt;
      end
      CMD_LO: lo_r <= mul_p;
      CMD_HI: pm_r <= lo_r + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
      CMD_RES: begin
        pos_out_r <= pos_sat[OUT_W-1:0];
        spd_out_r <= spd_sat[OUT_W-1:0];
        ph_out_r  <= ph_r;
      end
      default: begin
        t1_r <= t1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.cmd == CMD_RES) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.plan_valid = plan_valid_r;
  assign stat.trap       = trap;
  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;
  assign stat.out_free   = out_free;

  assign out_valid    = out_valid_r;
  assign out_position = pos_out_r;
  assign out_speed    = spd_out_r;
  assign out_phase    = ph_out_r;

endmodule

### design/tvp_ctrl.sv
// ----------------------------------------------------------------------------
// tvp_ctrl
// Sequencer for plan computation and per-sample evaluation.
// ----------------------------------------------------------------------------
module tvp_ctrl import tvp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [26:0] {
    S_IDLE  = 27'h0000001,
    S_SETUP = 27'h0000002,
    S_SQ_VM = 27'h0000004,
    S_SQ_V0 = 27'h0000008,
    S_SQ_V1 = 27'h0000010,
    S_AL    = 27'h0000020,
    S_CMP   = 27'h0000040,
    S_XD_GO = 27'h0000080,
    S_XD_WT = 27'h0000100,
    S_X1_GO = 27'h0000200,
    S_X1_WT = 27'h0000400,
    S_T1_GO = 27'h0000800,
    S_T1_WT = 27'h0001000,
    S_TC_GO = 27'h0002000,
    S_TC_WT = 27'h0004000,
    S_RT_GO = 27'h0008000,
    S_RT_WT = 27'h0010000,
    S_PK_SQ = 27'h0020000,
    S_TD_GO = 27'h0040000,
    S_TD_WT = 27'h0080000,
    S_FIN   = 27'h0100000,
    S_LOC   = 27'h0200000,
    S_DV    = 27'h0400000,
    S_MID   = 27'h0800000,
    S_LO    = 27'h1000000,
    S_HI    = 27'h2000000,
    S_RES   = 27'h4000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign take     = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl.cmd  = CMD_NONE;
    ctrl.take = take;
    case (state_r)
      S_IDLE: begin
        if (take) state_nxt = stat.plan_valid ? S_LOC : S_SETUP;
      end
      S_SETUP: begin
        ctrl.cmd  = CMD_SETUP;
        state_nxt = S_SQ_VM;
      end
      S_SQ_VM: begin
        ctrl.cmd  = CMD_SQ_VM;
        state_nxt = S_SQ_V0;
      end
      S_SQ_V0: begin
        ctrl.cmd  = CMD_SQ_V0;
        state_nxt = S_SQ_V1;
      end
      S_SQ_V1: begin
        ctrl.cmd  = CMD_SQ_V1;
        state_nxt = S_AL;
      end
      S_AL: begin
        ctrl.cmd  = CMD_AL;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = stat.trap ? S_XD_GO : S_RT_GO;
      end
      S_XD_GO: begin
        ctrl.cmd  = CMD_XD_GO;
        state_nxt = S_XD_WT;
      end
      S_XD_WT: begin
        ctrl.cmd = CMD_XD_ST;
        if (stat.div_done) state_nxt = S_X1_GO;
      end
      S_X1_GO: begin
        ctrl.cmd  = CMD_X1_GO;
        state_nxt = S_X1_WT;
      end
      S_X1_WT: begin
        ctrl.cmd = CMD_X1_ST;
        if (stat.div_done) state_nxt = S_T1_GO;
      end
      S_T1_GO: begin
        ctrl.cmd  = CMD_T1_GO;
        state_nxt = S_T1_WT;
      end
      S_T1_WT: begin
        ctrl.cmd = CMD_T1_ST;
        if (stat.div_done) state_nxt = stat.trap ? S_TC_GO : S_TD_GO;
      end
      S_TC_GO: begin
        ctrl.cmd  = CMD_TC_GO;
        state_nxt = S_TC_WT;
      end
      S_TC_WT: begin
        ctrl.cmd = CMD_TC_ST;
        if (stat.div_done) state_nxt = S_TD_GO;
      end
      S_RT_GO: begin
        ctrl.cmd  = CMD_RT_GO;
        state_nxt = S_RT_WT;
      end
      S_RT_WT: begin
        ctrl.cmd = CMD_RT_ST;
        if (stat.sqrt_done) state_nxt = S_PK_SQ;
      end
      S_PK_SQ: begin
        ctrl.cmd  = CMD_PK_SQ;
        state_nxt = S_X1_GO;
      end
      S_TD_GO: begin
        ctrl.cmd  = CMD_TD_GO;
        state_nxt = S_TD_WT;
      end
      S_TD_WT: begin
        ctrl.cmd = CMD_TD_ST;
        if (stat.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        ctrl.cmd  = CMD_FIN;
        state_nxt = S_LOC;
      end
      S_LOC: begin
        ctrl.cmd  = CMD_LOC;
        state_nxt = S_DV;
      end
      S_DV: begin
        ctrl.cmd  = CMD_DV;
        state_nxt = S_MID;
      end
      S_MID: begin
        ctrl.cmd  = CMD_MID;
        state_nxt = S_LO;
      end
      S_LO: begin
        ctrl.cmd  = CMD_LO;
        state_nxt = S_HI;
      end
      S_HI: begin
        ctrl.cmd  = CMD_HI;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          ctrl.cmd  = CMD_RES;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
